@@ rtl/vpic_pkg.sv @@
// Shared types, constants and saturation helper for the Verlet particle integrator.
// No dependencies; imported by every module of the block.
`default_nettype none
package vpic_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int FACTOR_BITS = 16;
	localparam int PROD_W      = 51;

	typedef logic signed [31:0] q_t;

	typedef struct packed {
		q_t   pos_x;
		q_t   pos_y;
		q_t   pos_z;
		q_t   prev_x;
		q_t   prev_y;
		q_t   prev_z;
		q_t   accel_x;
		q_t   accel_y;
		q_t   accel_z;
		logic pinned;
		logic last_in;
	} particle_t;

	typedef struct packed {
		q_t   new_pos_x;
		q_t   new_pos_y;
		q_t   new_pos_z;
		q_t   new_prev_x;
		q_t   new_prev_y;
		q_t   new_prev_z;
		logic accel_cleared;
		logic last_out;
	} result_t;

	typedef struct packed {
		q_t [2:0] pos;
		q_t [2:0] prev;
		logic     accel_cleared;
		logic     last;
	} mid_t;

	typedef struct packed {
		logic [16:0] friction;
		logic [16:0] bounciness;
		logic [30:0] bound_x;
		logic [30:0] bound_y;
		logic [30:0] bound_z;
		logic        confine_enable;
	} cfg_t;

	typedef enum logic [2:0] {
		REG_FRICTION   = 3'd0,
		REG_BOUNCINESS = 3'd1,
		REG_BOUND_X    = 3'd2,
		REG_BOUND_Y    = 3'd3,
		REG_BOUND_Z    = 3'd4,
		REG_CONFINE    = 3'd5
	} reg_idx_t;

	localparam logic [16:0] FRICTION_RST   = 17'd65208;
	localparam logic [16:0] BOUNCINESS_RST = 17'd13107;
	localparam logic [30:0] BOUND_RST      = 31'(10 << FRAC_BITS);

	// clamp to the signed 32 bit range
	function automatic q_t sat32(input logic signed [35:0] v);
		if (v[35:31] == {5{v[35]}}) begin
			return v[31:0];
		end else if (v[35]) begin
			return {1'b1, {31{1'b0}}};
		end else begin
			return {1'b0, {31{1'b1}}};
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/vpic_integ.sv @@
// Four-stage integration pipeline: difference, friction product, velocity add, accel add.
// Depends on vpic_pkg.
`default_nettype none
module vpic_integ
	import vpic_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire particle_t in_data,
	output logic           out_valid,
	input  wire logic      out_stall,
	output mid_t           out_data
);

	q_t p_in [3];
	q_t o_in [3];
	q_t a_in [3];

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	logic signed [32:0]       d_s1 [3];
	q_t                       p_s1 [3], o_s1 [3], a_s1 [3];
	logic                     pin_s1, last_s1;
	logic signed [PROD_W-1:0] m_s2 [3];
	q_t                       p_s2 [3], o_s2 [3], a_s2 [3];
	logic                     pin_s2, last_s2;
	q_t                       t_s3 [3];
	q_t                       p_s3 [3], o_s3 [3], a_s3 [3];
	logic                     pin_s3, last_s3;
	q_t                       pos_s4 [3], prev_s4 [3];
	logic                     pin_s4, last_s4;

	q_t vel_sat [3];

	logic signed [17:0] fric;
	assign fric = $signed({1'b0, cfg.friction});

	always_comb begin
		p_in[0] = in_data.pos_x;   p_in[1] = in_data.pos_y;   p_in[2] = in_data.pos_z;
		o_in[0] = in_data.prev_x;  o_in[1] = in_data.prev_y;  o_in[2] = in_data.prev_z;
		a_in[0] = in_data.accel_x; a_in[1] = in_data.accel_y; a_in[2] = in_data.accel_z;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vel_sat[i] = sat32({m_s2[i][PROD_W-1], m_s2[i][PROD_W-1:FACTOR_BITS]});
		end
	end

	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= {p_in[i][31], p_in[i]} - {o_in[i][31], o_in[i]};
				p_s1[i] <= p_in[i];
				o_s1[i] <= o_in[i];
				a_s1[i] <= a_in[i];
			end
			pin_s1  <= in_data.pinned;
			last_s1 <= in_data.last_in;
		end
		if (en2 && v_s1) begin
			for (int i = 0; i < 3; i++) begin
				m_s2[i] <= d_s1[i] * fric;
				p_s2[i] <= p_s1[i];
				o_s2[i] <= o_s1[i];
				a_s2[i] <= a_s1[i];
			end
			pin_s2  <= pin_s1;
			last_s2 <= last_s1;
		end
		if (en3 && v_s2) begin
			for (int i = 0; i < 3; i++) begin
				t_s3[i] <= sat32({{4{p_s2[i][31]}}, p_s2[i]}
					+ {{4{vel_sat[i][31]}}, vel_sat[i]});
				p_s3[i] <= p_s2[i];
				o_s3[i] <= o_s2[i];
				a_s3[i] <= a_s2[i];
			end
			pin_s3  <= pin_s2;
			last_s3 <= last_s2;
		end
		if (en4 && v_s3) begin
			for (int i = 0; i < 3; i++) begin
				if (pin_s3) begin
					pos_s4[i]  <= p_s3[i];
					prev_s4[i] <= o_s3[i];
				end else begin
					pos_s4[i]  <= sat32({{4{t_s3[i][31]}}, t_s3[i]}
						+ {{4{a_s3[i][31]}}, a_s3[i]});
					prev_s4[i] <= p_s3[i];
				end
			end
			pin_s4  <= pin_s3;
			last_s4 <= last_s3;
		end
	end

	assign out_valid = v_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			out_data.pos[i]  = pos_s4[i];
			out_data.prev[i] = prev_s4[i];
		end
		out_data.accel_cleared = !pin_s4;
		out_data.last          = last_s4;
	end

endmodule
`default_nettype wire

@@ rtl/vpic_confine.sv @@
// Three-stage box confinement pipeline: bound compare, bounciness product, clamp.
// Depends on vpic_pkg.
`default_nettype none
module vpic_confine
	import vpic_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  in_valid,
	output logic       in_stall,
	input  wire mid_t  in_data,
	output logic       out_valid,
	input  wire logic  out_stall,
	output result_t    out_data
);

	logic [30:0]        bnd [3];
	logic signed [32:0] bpos [3];
	logic signed [32:0] bneg [3];

	logic v_s5, v_s6, v_s7;
	logic en5, en6, en7;

	logic signed [32:0]       d_s5 [3];
	logic                     hi_s5 [3], lo_s5 [3];
	q_t                       pos_s5 [3], prev_s5 [3];
	logic                     clr_s5, last_s5;
	logic signed [PROD_W-1:0] m_s6 [3];
	logic                     hi_s6 [3], lo_s6 [3];
	q_t                       pos_s6 [3], prev_s6 [3];
	logic                     clr_s6, last_s6;
	q_t                       pos_s7 [3], prev_s7 [3];
	logic                     clr_s7, last_s7;

	logic signed [17:0] bnc;
	assign bnc = $signed({1'b0, cfg.bounciness});

	always_comb begin
		bnd[0] = cfg.bound_x;
		bnd[1] = cfg.bound_y;
		bnd[2] = cfg.bound_z;
		for (int i = 0; i < 3; i++) begin
			bpos[i] = $signed({2'b00, bnd[i]});
			bneg[i] = -$signed({2'b00, bnd[i]});
		end
	end

	assign en7      = !v_s7 || !out_stall;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign in_stall = !en5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en5) v_s5 <= in_valid;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en5 && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				d_s5[i]    <= {in_data.pos[i][31], in_data.pos[i]}
					- {in_data.prev[i][31], in_data.prev[i]};
				hi_s5[i]   <= cfg.confine_enable
					&& ($signed({in_data.pos[i][31], in_data.pos[i]}) > bpos[i]);
				lo_s5[i]   <= cfg.confine_enable
					&& ($signed({in_data.pos[i][31], in_data.pos[i]}) < bneg[i]);
				pos_s5[i]  <= in_data.pos[i];
				prev_s5[i] <= in_data.prev[i];
			end
			clr_s5  <= in_data.accel_cleared;
			last_s5 <= in_data.last;
		end
		if (en6 && v_s5) begin
			for (int i = 0; i < 3; i++) begin
				m_s6[i]    <= d_s5[i] * bnc;
				hi_s6[i]   <= hi_s5[i];
				lo_s6[i]   <= lo_s5[i];
				pos_s6[i]  <= pos_s5[i];
				prev_s6[i] <= prev_s5[i];
			end
			clr_s6  <= clr_s5;
			last_s6 <= last_s5;
		end
		if (en7 && v_s6) begin
			for (int i = 0; i < 3; i++) begin
				if (hi_s6[i]) begin
					pos_s7[i]  <= bpos[i][31:0];
					prev_s7[i] <= sat32({{3{bpos[i][32]}}, bpos[i]}
						+ {m_s6[i][PROD_W-1], m_s6[i][PROD_W-1:FACTOR_BITS]});
				end else if (lo_s6[i]) begin
					pos_s7[i]  <= bneg[i][31:0];
					prev_s7[i] <= sat32({{3{bneg[i][32]}}, bneg[i]}
						+ {m_s6[i][PROD_W-1], m_s6[i][PROD_W-1:FACTOR_BITS]});
				end else begin
					pos_s7[i]  <= pos_s6[i];
					prev_s7[i] <= prev_s6[i];
				end
			end
			clr_s7  <= clr_s6;
			last_s7 <= last_s6;
		end
	end

	assign out_valid = v_s7;

	always_comb begin
		out_data.new_pos_x     = pos_s7[0];
		out_data.new_pos_y     = pos_s7[1];
		out_data.new_pos_z     = pos_s7[2];
		out_data.new_prev_x    = prev_s7[0];
		out_data.new_prev_y    = prev_s7[1];
		out_data.new_prev_z    = prev_s7[2];
		out_data.accel_cleared = clr_s7;
		out_data.last_out      = last_s7;
	end

endmodule
`default_nettype wire

@@ rtl/verlet_particle_integrate_confine.sv @@
// Top level: configuration registers, integration pipeline and confinement pipeline.
// Depends on vpic_pkg, vpic_integ and vpic_confine.
//
// Streams one particle per clock, while the output is not stalled, through a seven-stage
// pipeline: four integration stages, then three confinement stages. The depth is set by the
// two multipliers in the path (friction on the velocity, bounciness at a clamp), each with a
// register on either side, plus the saturating adds. Every stage holds independently, so
// bubbles close up under a stalled output and a particle is taken whenever any stage has
// room. Write configuration only with the pipeline empty.
`default_nettype none
module verlet_particle_integrate_confine
	import vpic_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [30:0] cfg_data,
	input  wire logic        particle_valid,
	output logic             particle_stall,
	input  wire particle_t   particle,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result
);

	cfg_t cfg_q;
	logic mid_valid;
	logic mid_stall;
	mid_t mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.friction       <= FRICTION_RST;
			cfg_q.bounciness     <= BOUNCINESS_RST;
			cfg_q.bound_x        <= BOUND_RST;
			cfg_q.bound_y        <= BOUND_RST;
			cfg_q.bound_z        <= BOUND_RST;
			cfg_q.confine_enable <= 1'b1;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FRICTION:   cfg_q.friction       <= cfg_data[16:0];
				REG_BOUNCINESS: cfg_q.bounciness     <= cfg_data[16:0];
				REG_BOUND_X:    cfg_q.bound_x        <= cfg_data;
				REG_BOUND_Y:    cfg_q.bound_y        <= cfg_data;
				REG_BOUND_Z:    cfg_q.bound_z        <= cfg_data;
				REG_CONFINE:    cfg_q.confine_enable <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	vpic_integ u_integ (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (particle_valid),
		.in_stall  (particle_stall),
		.in_data   (particle),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.out_data  (mid)
	);

	vpic_confine u_confine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (mid_valid),
		.in_stall  (mid_stall),
		.in_data   (mid),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.out_data  (result)
	);

endmodule
`default_nettype wire

@@ rtl/vpic_checker.sv @@
// Port-level checks for the integrator: output hold, stall origin and pipeline latency.
// Depends on vpic_pkg; bound to verlet_particle_integrate_confine.
`default_nettype none
module vpic_checker
	import vpic_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      particle_valid,
	input wire logic      particle_stall,
	input wire particle_t particle,
	input wire logic      result_valid,
	input wire logic      result_stall,
	input wire result_t   result
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	a_stall_origin: assert property (@(posedge clk) disable iff (!arst_n)
		particle_stall |-> result_valid && result_stall)
		else $error("input stalled while output free");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(particle_valid && !particle_stall) ##1 !result_stall ##1 !result_stall
			##1 !result_stall ##1 !result_stall ##1 !result_stall ##1 !result_stall
			|=> result_valid)
		else $error("transfer did not reach output in seven cycles");

	a_no_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> !particle_stall)
		else $error("input stalled with empty output stage");

endmodule

bind verlet_particle_integrate_confine vpic_checker u_vpic_checker (.*);
`default_nettype wire

@@ sim/verlet_particle_integrate_confine_tb.sv @@
// Self-checking testbench for verlet_particle_integrate_confine: directed and random particles,
// random idling on both channels, two long output hold-offs and several register settings.
// Depends on vpic_pkg and the RTL top level only.
`timescale 1ns / 100ps

module verlet_particle_integrate_confine_tb;
	import vpic_pkg::*;

	localparam q_t Q_MAX = 32'sh7fff_ffff;
	localparam q_t Q_MIN = 32'sh8000_0000;
	localparam logic [30:0] BOUND_MAX = 31'h7fff_ffff;
	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic particle_valid = 1'b0;
	logic particle_stall;
	particle_t particle = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	// register image used for prediction
	logic [16:0] friction_q16 = FRICTION_RST;
	logic [16:0] bounciness_q16 = BOUNCINESS_RST;
	logic [30:0] half_box [3] = '{BOUND_RST, BOUND_RST, BOUND_RST};
	logic confine_on = 1'b1;

	particle_t particles_to_send [$];
	result_t predicted_results [$];
	int items_issued = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	bit took_item = 1'b0;
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	int src_gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hold_at = 60;

	verlet_particle_integrate_confine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.particle_valid(particle_valid),
		.particle_stall(particle_stall),
		.particle(particle),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint clip32(longint v);
		if (v > longint'(Q_MAX)) begin
			return longint'(Q_MAX);
		end else if (v < longint'(Q_MIN)) begin
			return longint'(Q_MIN);
		end
		return v;
	endfunction

	// floor(d * f / 2^16)
	function automatic longint scale_q16(longint d, logic [16:0] f);
		longint prod;
		prod = d * longint'(f);
		return prod >>> FACTOR_BITS;
	endfunction

	function automatic result_t integrate_particle(particle_t p);
		longint pos [3];
		longint prv [3];
		longint acc [3];
		longint bnd [3];
		longint vel;
		longint np;
		result_t r;
		pos = '{longint'(p.pos_x), longint'(p.pos_y), longint'(p.pos_z)};
		prv = '{longint'(p.prev_x), longint'(p.prev_y), longint'(p.prev_z)};
		acc = '{longint'(p.accel_x), longint'(p.accel_y), longint'(p.accel_z)};
		for (int i = 0; i < 3; i++) begin
			bnd[i] = longint'(half_box[i]);
			if (!p.pinned) begin
				vel = clip32(scale_q16(pos[i] - prv[i], friction_q16));
				np = clip32(clip32(pos[i] + vel) + acc[i]);
				prv[i] = pos[i];
				pos[i] = np;
			end
			if (confine_on) begin
				vel = pos[i] - prv[i];
				if (pos[i] > bnd[i]) begin
					pos[i] = bnd[i];
					prv[i] = clip32(bnd[i] + scale_q16(vel, bounciness_q16));
				end
				if (pos[i] < -bnd[i]) begin
					pos[i] = -bnd[i];
					prv[i] = clip32(-bnd[i] + scale_q16(vel, bounciness_q16));
				end
			end
		end
		r.new_pos_x = q_t'(pos[0]);
		r.new_pos_y = q_t'(pos[1]);
		r.new_pos_z = q_t'(pos[2]);
		r.new_prev_x = q_t'(prv[0]);
		r.new_prev_y = q_t'(prv[1]);
		r.new_prev_z = q_t'(prv[2]);
		r.accel_cleared = !p.pinned;
		r.last_out = p.last_in;
		return r;
	endfunction

	function automatic int idle_length();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic q_t random_coord(longint b);
		longint v;
		case ($urandom_range(0, 9))
			0, 1: begin
				v = longint'(q_t'($urandom));
			end
			2: begin
				v = $urandom_range(0, 1) ? longint'(Q_MAX) : longint'(Q_MIN);
			end
			3, 4, 5, 6: begin
				v = b + longint'($urandom_range(0, 262144)) - 131072;
				if ($urandom_range(0, 1)) begin
					v = -v;
				end
			end
			default: begin
				v = longint'($urandom_range(0, 2097152)) - 1048576;
			end
		endcase
		return q_t'(clip32(v));
	endfunction

	function automatic particle_t random_particle();
		q_t pc [3];
		q_t oc [3];
		q_t ac [3];
		int unsigned pick;
		particle_t pt;
		for (int i = 0; i < 3; i++) begin
			pc[i] = random_coord(longint'(half_box[i]));
			if ($urandom_range(0, 9) < 7) begin
				oc[i] = q_t'(clip32(longint'(pc[i]) - longint'($urandom_range(0, 524288)) + 262144));
			end else begin
				oc[i] = random_coord(longint'(half_box[i]));
			end
			pick = $urandom_range(0, 19);
			if (pick < 14) begin
				ac[i] = q_t'(longint'($urandom_range(0, 32768)) - 16384);
			end else if (pick < 17) begin
				ac[i] = q_t'($urandom);
			end else begin
				ac[i] = '0;
			end
		end
		pt = particle_t'{pos_x: pc[0], pos_y: pc[1], pos_z: pc[2],
			prev_x: oc[0], prev_y: oc[1], prev_z: oc[2],
			accel_x: ac[0], accel_y: ac[1], accel_z: ac[2],
			pinned: ($urandom_range(0, 4) == 0), last_in: ($urandom_range(0, 7) == 0)};
		return pt;
	endfunction

	function automatic particle_t uniform_particle(q_t p, q_t o, q_t a, logic pin, logic last);
		return particle_t'{pos_x: p, pos_y: p, pos_z: p, prev_x: o, prev_y: o, prev_z: o,
			accel_x: a, accel_y: a, accel_z: a, pinned: pin, last_in: last};
	endfunction

	task automatic note_failure(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endtask

	task automatic compare_result(result_t want, result_t got);
		if (want.new_pos_x !== got.new_pos_x)
			note_failure($sformatf("new_pos_x expected %0d got %0d", want.new_pos_x, got.new_pos_x));
		if (want.new_pos_y !== got.new_pos_y)
			note_failure($sformatf("new_pos_y expected %0d got %0d", want.new_pos_y, got.new_pos_y));
		if (want.new_pos_z !== got.new_pos_z)
			note_failure($sformatf("new_pos_z expected %0d got %0d", want.new_pos_z, got.new_pos_z));
		if (want.new_prev_x !== got.new_prev_x)
			note_failure($sformatf("new_prev_x expected %0d got %0d", want.new_prev_x,
				got.new_prev_x));
		if (want.new_prev_y !== got.new_prev_y)
			note_failure($sformatf("new_prev_y expected %0d got %0d", want.new_prev_y,
				got.new_prev_y));
		if (want.new_prev_z !== got.new_prev_z)
			note_failure($sformatf("new_prev_z expected %0d got %0d", want.new_prev_z,
				got.new_prev_z));
		if (want.accel_cleared !== got.accel_cleared)
			note_failure($sformatf("accel_cleared expected %b got %b", want.accel_cleared,
				got.accel_cleared));
		if (want.last_out !== got.last_out)
			note_failure($sformatf("last_out expected %b got %b", want.last_out, got.last_out));
	endtask

	task automatic queue_particle(particle_t p);
		particles_to_send.push_back(p);
		items_issued++;
	endtask

	task automatic put_reg(reg_idx_t idx, logic [30:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_FRICTION: friction_q16 = val[16:0];
			REG_BOUNCINESS: bounciness_q16 = val[16:0];
			REG_BOUND_X: half_box[0] = val;
			REG_BOUND_Y: half_box[1] = val;
			REG_BOUND_Z: half_box[2] = val;
			REG_CONFINE: confine_on = val[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(logic [16:0] fr, logic [16:0] bn, logic [30:0] bx,
		logic [30:0] by, logic [30:0] bz, logic en);
		put_reg(REG_FRICTION, 31'(fr));
		put_reg(REG_BOUNCINESS, 31'(bn));
		put_reg(REG_BOUND_X, bx);
		put_reg(REG_BOUND_Y, by);
		put_reg(REG_BOUND_Z, bz);
		put_reg(REG_CONFINE, 31'(en));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (results_seen < items_issued) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(bit src_idle, bit sink_idle, int count);
		src_idle_on = src_idle;
		sink_idle_on = sink_idle;
		repeat (count) queue_particle(random_particle());
		drain();
	endtask

	// sender: hold the payload until the transfer, then idle or offer the next particle
	always @(negedge clk) begin
		if (!particle_valid || took_item) begin
			if (arst_n && src_gap_left == 0 && particles_to_send.size() != 0) begin
				particle <= particles_to_send.pop_front();
				particle_valid <= 1'b1;
				if (src_idle_on) begin
					src_gap_left = idle_length();
				end
			end else begin
				particle_valid <= 1'b0;
				if (src_gap_left > 0) begin
					src_gap_left--;
				end
			end
		end
		took_item = 1'b0;
	end

	// receiver stall: random gaps plus two long hold-offs to back the pipeline up
	always @(negedge clk) begin
		if (hold_at != 0 && results_seen >= hold_at) begin
			hold_left = 400;
			hold_at = (hold_at == 60) ? 450 : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (sink_idle_on) begin
				stall_left = idle_length();
			end
		end
	end

	// monitor: predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		if (arst_n && particle_valid && !particle_stall) begin
			predicted_results.push_back(integrate_particle(particle));
			took_item = 1'b1;
		end
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (predicted_results.size() == 0) begin
				note_failure("result with no particle outstanding");
			end else begin
				compare_result(predicted_results.pop_front(), result);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: bound 10.0, friction 0.995, bounciness 0.2, confinement on
		queue_particle(uniform_particle(32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0));
		queue_particle(uniform_particle(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1));
		queue_particle(uniform_particle(Q_MAX, Q_MIN, Q_MAX, 1'b0, 1'b0));
		queue_particle(uniform_particle(Q_MIN, Q_MAX, Q_MIN, 1'b0, 1'b0));
		queue_particle(uniform_particle(32'sd196608, 32'sd131072, 32'sd32768, 1'b0, 1'b0));
		queue_particle(uniform_particle(32'sd622592, 32'sd524288, 32'sd0, 1'b0, 1'b0));
		queue_particle(uniform_particle(-32'sd622592, -32'sd524288, 32'sd0, 1'b0, 1'b0));
		// pinned outside the box still gets clamped
		queue_particle(uniform_particle(32'sd1310720, 32'sd1245184, 32'sd65536, 1'b1, 1'b0));
		queue_particle(uniform_particle(-32'sd1310720, -32'sd1245184, 32'sd0, 1'b1, 1'b1));
		queue_particle(uniform_particle(32'sd655360, 32'sd655360, 32'sd0, 1'b0, 1'b0));
		queue_particle(uniform_particle(-32'sd655360, -32'sd655360, 32'sd0, 1'b0, 1'b0));
		queue_particle(uniform_particle(32'sd0, 32'sd0, Q_MAX, 1'b0, 1'b0));
		queue_particle(uniform_particle(32'sd0, 32'sd1, 32'sd0, 1'b0, 1'b0));
		queue_particle(uniform_particle(-32'sd1, -32'sd1, -32'sd1, 1'b1, 1'b1));
		queue_particle(uniform_particle(Q_MAX, Q_MAX, Q_MAX, 1'b1, 1'b0));
		queue_particle(uniform_particle(32'sd655361, 32'sd0, 32'sd0, 1'b0, 1'b1));
		queue_particle(particle_t'{pos_x: 32'shAAAA_AAAA, pos_y: 32'sh5555_5555,
			pos_z: 32'sh0001_8000, prev_x: 32'sh5555_5555, prev_y: 32'shAAAA_AAAA,
			prev_z: -32'sh0001_8000, accel_x: 32'sh5555_5555, accel_y: 32'shAAAA_AAAA,
			accel_z: Q_MIN, pinned: 1'b0, last_in: 1'b1});
		run_phase(1'b1, 1'b1, 200);

		// unity factors, widest box
		apply_settings(17'd65536, 17'd65536, BOUND_MAX, BOUND_MAX, BOUND_MAX, 1'b1);
		run_phase(1'b1, 1'b1, 120);

		// zero factors, zero box
		apply_settings(17'd0, 17'd0, 31'd0, 31'd0, 31'd0, 1'b1);
		run_phase(1'b0, 1'b1, 120);

		// factors above one, random box
		apply_settings(17'h1ffff, 17'h1ffff, 31'($urandom), 31'($urandom), 31'($urandom), 1'b1);
		run_phase(1'b1, 1'b0, 120);

		// confinement off
		apply_settings(17'($urandom), 17'($urandom), 31'($urandom), 31'($urandom),
			31'($urandom), 1'b0);
		run_phase(1'b0, 1'b0, 120);

		// small random box
		apply_settings(17'($urandom), 17'($urandom), 31'($urandom_range(0, 1 << 22)),
			31'($urandom_range(0, 1 << 22)), 31'($urandom_range(0, 1 << 22)), 1'b1);
		run_phase(1'b1, 1'b1, 120);

		if (predicted_results.size() != 0) begin
			note_failure($sformatf("%0d results never arrived", predicted_results.size()));
		end
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
